[hw/rtl/wavhdr_pkg.sv]
`timescale 1ns / 1ps

package wavhdr_pkg;

    localparam int unsigned POS_W      = 26;
    localparam int unsigned REMAIN_W   = 33;
    localparam int unsigned OFF_W      = 5;
    localparam int unsigned STATUS_W   = 4;
    localparam int unsigned CHAN_W     = 2;
    localparam int unsigned RATE_W     = 17;
    localparam int unsigned BITS_W     = 5;

    localparam int unsigned DEF_MAX_FILE_BYTES = 50 * 1024 * 1024;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Four-character codes as they appear in little-endian byte order.
    localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
    localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
    localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;
    localparam logic [31:0] DATA_TAG = 32'h6174_6164;

    localparam logic [31:0] MAX_RATE      = 32'd96000;
    localparam logic [POS_W-1:0] MIN_FILE = 26'd44;
    localparam logic [31:0] MIN_FMT_LEN   = 32'd16;
    localparam logic [OFF_W-1:0] FMT_CAPTURE_END = 5'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_TAGS     = 4'd2,
        ST_CHUNKS   = 4'd3,
        ST_NOT_PCM  = 4'd4,
        ST_CHANNELS = 4'd5,
        ST_BITS     = 4'd6,
        ST_RATE     = 4'd7,
        ST_TOO_BIG  = 4'd8
    } status_t;

    typedef enum logic [3:0] {
        PH_RIFF = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_STOP = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } chunk_kind_t;

    typedef struct packed {
        logic                valid;
        status_t             status;
        logic [CHAN_W-1:0]   channels;
        logic [RATE_W-1:0]   sample_rate;
        logic [BITS_W-1:0]   bits_per_sample;
        logic [POS_W-1:0]    pcm_offset;
        logic [POS_W-1:0]    pcm_bytes;
    } result_t;

endpackage

[hw/rtl/wavhdr_if.sv]
`timescale 1ns / 1ps

interface wavhdr_byte_if ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wavhdr_result_if import wavhdr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHAN_W-1:0]   channels;
    logic [RATE_W-1:0]   sample_rate;
    logic [BITS_W-1:0]   bits_per_sample;
    logic [POS_W-1:0]    pcm_offset;
    logic [POS_W-1:0]    pcm_bytes;

    modport source (output valid, output status, output channels, output sample_rate,
                    output bits_per_sample, output pcm_offset, output pcm_bytes,
                    input ready);
    modport sink (input valid, input status, input channels, input sample_rate,
                  input bits_per_sample, input pcm_offset, input pcm_bytes,
                  output ready);
endinterface

[hw/rtl/wavhdr_walker.sv]
`timescale 1ns / 1ps

module wavhdr_walker import wavhdr_pkg::*; #(
    parameter int unsigned MAX_FILE_BYTES = DEF_MAX_FILE_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic [POS_W-1:0] file_length,
    output result_t          res
);

    logic [POS_W-1:0]    pos_reg, pos_next;
    phase_t              phase_reg, phase_next;
    logic                tags_ok_reg, tags_ok_next;
    logic [63:0]         hdr_reg, hdr_next;
    chunk_kind_t         kind_reg, kind_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic                fmt_seen_reg, fmt_seen_next;
    logic [31:0]         fmt_len_reg, fmt_len_next;
    logic [15:0]         fmt_tag_reg, fmt_tag_next;
    logic [15:0]         chan_reg, chan_next;
    logic [31:0]         rate_reg, rate_next;
    logic [15:0]         bits_reg, bits_next;
    logic                data_seen_reg, data_seen_next;
    logic [POS_W-1:0]    data_start_reg, data_start_next;
    logic [31:0]         data_len_reg, data_len_next;

    logic [POS_W:0]      body;
    logic [63:0]         hdr_shift;
    logic [31:0]         chunk_size;
    logic [REMAIN_W-1:0] remain_dec;
    logic                tag_match;
    status_t             status;

    // A chunk header starting at the given offset must fit inside the file.
    function automatic logic header_fits(input logic [POS_W:0] start,
                                         input logic [POS_W-1:0] flen);
        return ({1'b0, start} + (POS_W + 2)'(8)) <= {2'b00, flen};
    endfunction

    assign body       = {1'b0, pos_reg} + (POS_W + 1)'(1);
    assign hdr_shift  = {data_byte, hdr_reg[63:8]};
    assign chunk_size = hdr_shift[63:32];
    assign remain_dec = remain_reg - REMAIN_W'(1);

    always_comb
    begin
        tag_match = 1'b1;
        if (pos_reg < POS_W'(4))
        begin
            tag_match = (data_byte == RIFF_TAG[8*pos_reg[1:0] +: 8]);
        end
        else if (pos_reg >= POS_W'(8) && pos_reg < POS_W'(12))
        begin
            tag_match = (data_byte == WAVE_TAG[8*pos_reg[1:0] +: 8]);
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        tags_ok_next    = tags_ok_reg;
        hdr_next        = hdr_reg;
        kind_next       = kind_reg;
        remain_next     = remain_reg;
        off_next        = off_reg;
        fmt_seen_next   = fmt_seen_reg;
        fmt_len_next    = fmt_len_reg;
        fmt_tag_next    = fmt_tag_reg;
        chan_next       = chan_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        data_seen_next  = data_seen_reg;
        data_start_next = data_start_reg;
        data_len_next   = data_len_reg;
        pos_next        = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

        case (phase_reg)
            PH_RIFF:
            begin
                if (pos_reg == '0)
                begin
                    tags_ok_next = tag_match;
                end
                else
                begin
                    tags_ok_next = tags_ok_reg && tag_match;
                end
                if (pos_reg >= POS_W'(11))
                begin
                    if (header_fits((POS_W + 1)'(12), file_length))
                    begin
                        phase_next  = PH_HDR;
                        remain_next = REMAIN_W'(8);
                        hdr_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_HDR:
            begin
                hdr_next    = hdr_shift;
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    if (({6'b0, body} + {1'b0, chunk_size}) > {7'b0, file_length})
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        if (hdr_shift[31:0] == FMT_TAG)
                        begin
                            kind_next     = KIND_FMT;
                            fmt_seen_next = 1'b1;
                            fmt_len_next  = chunk_size;
                            fmt_tag_next  = '0;
                            chan_next     = '0;
                            rate_next     = '0;
                            bits_next     = '0;
                        end
                        else if (hdr_shift[31:0] == DATA_TAG)
                        begin
                            kind_next       = KIND_DATA;
                            data_seen_next  = 1'b1;
                            data_start_next = body[POS_W-1:0];
                            data_len_next   = chunk_size;
                        end
                        else
                        begin
                            kind_next = KIND_OTHER;
                        end
                        // Odd-sized chunks carry one pad byte.
                        remain_next = {1'b0, chunk_size} + REMAIN_W'(chunk_size[0]);
                        off_next    = '0;
                        if (chunk_size == '0)
                        begin
                            if (header_fits(body, file_length))
                            begin
                                phase_next  = PH_HDR;
                                remain_next = REMAIN_W'(8);
                                hdr_next    = '0;
                            end
                            else
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
            end
            PH_BODY:
            begin
                if (kind_reg == KIND_FMT && off_reg < FMT_CAPTURE_END)
                begin
                    if (off_reg < OFF_W'(2))
                    begin
                        fmt_tag_next[8*off_reg[0] +: 8] = data_byte;
                    end
                    else if (off_reg < OFF_W'(4))
                    begin
                        chan_next[8*off_reg[0] +: 8] = data_byte;
                    end
                    else if (off_reg < OFF_W'(8))
                    begin
                        rate_next[8*off_reg[1:0] +: 8] = data_byte;
                    end
                    else if (off_reg >= OFF_W'(14))
                    begin
                        bits_next[8*off_reg[0] +: 8] = data_byte;
                    end
                end
                if (off_reg < FMT_CAPTURE_END)
                begin
                    off_next = off_reg + OFF_W'(1);
                end
                remain_next = remain_dec;
                if (remain_dec == '0)
                begin
                    if (header_fits(body, file_length))
                    begin
                        phase_next  = PH_HDR;
                        remain_next = REMAIN_W'(8);
                        hdr_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_STOP:
            begin
                phase_next = PH_STOP;
            end
            default:
            begin
                phase_next = PH_STOP;
            end
        endcase
    end

    // The verdict is taken on the state as it stands after the last byte.
    always_comb
    begin
        if (file_length < MIN_FILE)
        begin
            status = ST_SHORT;
        end
        else if (!tags_ok_next || phase_next == PH_RIFF)
        begin
            status = ST_TAGS;
        end
        else if (!fmt_seen_next || fmt_len_next < MIN_FMT_LEN || !data_seen_next
                 || data_len_next == '0)
        begin
            status = ST_CHUNKS;
        end
        else if (fmt_tag_next != 16'd1)
        begin
            status = ST_NOT_PCM;
        end
        else if (chan_next == '0 || chan_next > 16'd2)
        begin
            status = ST_CHANNELS;
        end
        else if (bits_next != 16'd8 && bits_next != 16'd16)
        begin
            status = ST_BITS;
        end
        else if (rate_next == '0 || rate_next > MAX_RATE)
        begin
            status = ST_RATE;
        end
        else if (data_len_next > 32'(MAX_FILE_BYTES))
        begin
            status = ST_TOO_BIG;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        res        = '0;
        res.valid  = step && last_byte;
        res.status = status;
        if (status == ST_OK)
        begin
            res.channels        = chan_next[CHAN_W-1:0];
            res.sample_rate     = rate_next[RATE_W-1:0];
            res.bits_per_sample = bits_next[BITS_W-1:0];
            res.pcm_offset      = data_start_next;
            res.pcm_bytes       = data_len_next[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hdr_reg <= hdr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_RIFF;
            tags_ok_reg    <= 1'b0;
            kind_reg       <= KIND_OTHER;
            remain_reg     <= '0;
            off_reg        <= '0;
            fmt_seen_reg   <= 1'b0;
            fmt_len_reg    <= '0;
            fmt_tag_reg    <= '0;
            chan_reg       <= '0;
            rate_reg       <= '0;
            bits_reg       <= '0;
            data_seen_reg  <= 1'b0;
            data_start_reg <= '0;
            data_len_reg   <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // The file is finished: start over for the next one.
                pos_reg        <= '0;
                phase_reg      <= PH_RIFF;
                tags_ok_reg    <= 1'b0;
                kind_reg       <= KIND_OTHER;
                remain_reg     <= '0;
                off_reg        <= '0;
                fmt_seen_reg   <= 1'b0;
                fmt_len_reg    <= '0;
                fmt_tag_reg    <= '0;
                chan_reg       <= '0;
                rate_reg       <= '0;
                bits_reg       <= '0;
                data_seen_reg  <= 1'b0;
                data_start_reg <= '0;
                data_len_reg   <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                phase_reg      <= phase_next;
                tags_ok_reg    <= tags_ok_next;
                kind_reg       <= kind_next;
                remain_reg     <= remain_next;
                off_reg        <= off_next;
                fmt_seen_reg   <= fmt_seen_next;
                fmt_len_reg    <= fmt_len_next;
                fmt_tag_reg    <= fmt_tag_next;
                chan_reg       <= chan_next;
                rate_reg       <= rate_next;
                bits_reg       <= bits_next;
                data_seen_reg  <= data_seen_next;
                data_start_reg <= data_start_next;
                data_len_reg   <= data_len_next;
            end
        end
    end

endmodule

[hw/rtl/wav_header_parser.sv]
`timescale 1ns / 1ps

// WAV header parser. Set file_length through file_length_we/file_length_wdata while
// idle, then stream the file into byte_stream one byte per transfer, with last_byte
// high on the final byte. Each file yields exactly one transfer on result: a status
// code and, when the status is zero, the channel count, sample rate, sample width,
// payload offset and payload size of the last fmt and data chunks.
// A byte is taken every cycle unless a last byte waits on a stalled result. It sits
// in the input register and is parsed from there; parsing a last byte also loads the
// result register, which then presents the result. Each byte is parsed in a single
// pass through the chunk walker, so without stalls the rate is one byte per cycle.
// The result register holds a result until it is taken; while it is stalled, bytes
// that are not last keep flowing, and a second last byte waits in the input
// register, which then deasserts byte_stream.ready.
// Reset clears file_length to zero, drops any pending result and returns the
// walker to the start of a file. After each result the walker starts over by
// itself, keeping file_length.
module wav_header_parser import wavhdr_pkg::*; #(
    parameter int unsigned MAX_FILE_BYTES = DEF_MAX_FILE_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                file_length_we,
    input  logic [POS_W-1:0]    file_length_wdata,
    wavhdr_byte_if.sink         byte_stream,
    wavhdr_result_if.source     result
);

    logic [POS_W-1:0] file_length_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          walk_res;
    logic             advance;
    logic             step;

    // A last byte may only be parsed when the result register can take its result.
    assign advance = !in_last_reg || !out_valid_reg || result.ready;
    assign step    = in_valid_reg && advance;

    assign byte_stream.ready = !in_valid_reg || advance;

    wavhdr_walker #(
        .MAX_FILE_BYTES (MAX_FILE_BYTES)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .file_length (file_length_reg),
        .res         (walk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (file_length_we)
        begin
            file_length_reg <= file_length_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_stream.valid && byte_stream.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (walk_res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_stream.valid && byte_stream.ready)
        begin
            in_byte_reg <= byte_stream.data_byte;
            in_last_reg <= byte_stream.last_byte;
        end
        if (walk_res.valid)
        begin
            out_reg <= walk_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = out_reg.status;
    assign result.channels        = out_reg.channels;
    assign result.sample_rate     = out_reg.sample_rate;
    assign result.bits_per_sample = out_reg.bits_per_sample;
    assign result.pcm_offset      = out_reg.pcm_offset;
    assign result.pcm_bytes       = out_reg.pcm_bytes;

endmodule

[test/wav_header_parser_test.sv]
`timescale 1ns / 1ps

module wav_header_parser_test;
    import wavhdr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned FILE_TARGET = 40;
    localparam logic [15:0] PCM_FORMAT = 16'd1;
    localparam int unsigned COMMON_RATES [6] = '{8000, 11025, 22050, 44100, 48000, 96000};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        status_t             status;
        logic [CHAN_W-1:0]   channels;
        logic [RATE_W-1:0]   sample_rate;
        logic [BITS_W-1:0]   bits_per_sample;
        logic [POS_W-1:0]    pcm_offset;
        logic [POS_W-1:0]    pcm_bytes;
    } wav_summary_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [POS_W-1:0] cfg_data = '0;
    logic drv_valid = 1'b0;
    logic [7:0] drv_byte = 8'd0;
    logic drv_last = 1'b0;
    logic res_ready = 1'b0;

    wavhdr_byte_if byte_if ();
    wavhdr_result_if res_if ();

    assign byte_if.valid = drv_valid;
    assign byte_if.data_byte = drv_byte;
    assign byte_if.last_byte = drv_last;
    assign res_if.ready = res_ready;

    wav_header_parser i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .file_length_we    (cfg_we),
        .file_length_wdata (cfg_data),
        .byte_stream       (byte_if),
        .result            (res_if)
    );

    always #10 clk = ~clk;

    // Byte stream waiting to be sent, and the summaries the parser owes us.
    stream_byte_t byte_queue[$];
    wav_summary_t results_due[$];
    logic [7:0] wav_buf[$];

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned files_sent = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left [2] = '{0, 0};
    bit byte_fired = 1'b0;
    stream_byte_t next_byte;
    wav_summary_t seen;
    wav_summary_t want;

    // Shadow copy of the parser state.
    logic [POS_W-1:0] len_model;
    logic [POS_W-1:0] pos_model;
    phase_t phase_model;
    bit tags_good;
    logic [63:0] hdr_shift;
    chunk_kind_t kind_model;
    logic [32:0] remain_model;
    bit fmt_found;
    logic [31:0] fmt_size;
    logic [15:0] fmt_code;
    logic [15:0] chan_count;
    logic [31:0] rate_hz;
    logic [15:0] width_bits;
    bit data_found;
    logic [POS_W-1:0] data_pos;
    logic [31:0] data_size;

    function automatic void clear_walk();
        pos_model = '0;
        phase_model = PH_RIFF;
        tags_good = 1'b0;
        hdr_shift = '0;
        kind_model = KIND_OTHER;
        remain_model = '0;
        fmt_found = 1'b0;
        fmt_size = '0;
        fmt_code = '0;
        chan_count = '0;
        rate_hz = '0;
        width_bits = '0;
        data_found = 1'b0;
        data_pos = '0;
        data_size = '0;
    endfunction

    function automatic void begin_header(input logic [63:0] start);
        if (start + 64'd8 <= {38'd0, len_model})
        begin
            phase_model = PH_HDR;
            remain_model = 33'd8;
            hdr_shift = '0;
        end
        else
        begin
            phase_model = PH_STOP;
        end
    endfunction

    function automatic void capture_fmt(input logic [63:0] off, input logic [7:0] b);
        int sh;
        sh = off[0] ? 8 : 0;
        if (off < 64'd2)
            fmt_code |= {8'd0, b} << sh;
        else if (off < 64'd4)
            chan_count |= {8'd0, b} << sh;
        else if (off < 64'd8)
            rate_hz |= {24'd0, b} << (8 * off[1:0]);
        else if (off >= 64'd14 && off < 64'd16)
            width_bits |= {8'd0, b} << sh;
    endfunction

    function automatic void walk_byte(input logic [POS_W-1:0] cur, input logic [7:0] b);
        bit m;
        bit chk;
        logic [31:0] tag;
        logic [31:0] size;
        logic [63:0] body;
        logic [63:0] padded;
        case (phase_model)
            PH_RIFF:
            begin
                m = 1'b1;
                chk = 1'b0;
                if (cur < 4)
                begin
                    m = (b == RIFF_TAG[cur * 8 +: 8]);
                    chk = 1'b1;
                end
                else if (cur >= 8 && cur < 12)
                begin
                    m = (b == WAVE_TAG[(cur - 8) * 8 +: 8]);
                    chk = 1'b1;
                end
                if (cur == 0)
                    tags_good = m;
                else if (chk)
                    tags_good = tags_good && m;
                if (cur >= 11)
                    begin_header(64'd12);
            end
            PH_HDR:
            begin
                hdr_shift = {b, hdr_shift[63:8]};
                remain_model = remain_model - 33'd1;
                if (remain_model == 0)
                begin
                    tag = hdr_shift[31:0];
                    size = hdr_shift[63:32];
                    body = {38'd0, cur} + 64'd1;
                    // A chunk that would run past the end stops the walk.
                    if (body + {32'd0, size} > {38'd0, len_model})
                    begin
                        phase_model = PH_STOP;
                    end
                    else
                    begin
                        if (tag == FMT_TAG)
                        begin
                            kind_model = KIND_FMT;
                            fmt_found = 1'b1;
                            fmt_size = size;
                            fmt_code = '0;
                            chan_count = '0;
                            rate_hz = '0;
                            width_bits = '0;
                        end
                        else if (tag == DATA_TAG)
                        begin
                            kind_model = KIND_DATA;
                            data_found = 1'b1;
                            data_pos = body[POS_W-1:0];
                            data_size = size;
                        end
                        else
                        begin
                            kind_model = KIND_OTHER;
                        end
                        remain_model = {1'b0, size} + size[0];
                        if (remain_model == 0)
                            begin_header(body);
                        else
                            phase_model = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (kind_model == KIND_FMT)
                begin
                    padded = {32'd0, fmt_size} + fmt_size[0];
                    capture_fmt(padded - {31'd0, remain_model}, b);
                end
                remain_model = remain_model - 33'd1;
                if (remain_model == 0)
                    begin_header({38'd0, cur} + 64'd1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic wav_summary_t summarize();
        status_t st;
        wav_summary_t r;
        if (len_model < MIN_FILE)
            st = ST_SHORT;
        else if (!tags_good || phase_model == PH_RIFF)
            st = ST_TAGS;
        else if (!fmt_found || fmt_size < MIN_FMT_LEN || !data_found || data_size == 0)
            st = ST_CHUNKS;
        else if (fmt_code != PCM_FORMAT)
            st = ST_NOT_PCM;
        else if (chan_count == 0 || chan_count > 2)
            st = ST_CHANNELS;
        else if (width_bits != 16'd8 && width_bits != 16'd16)
            st = ST_BITS;
        else if (rate_hz == 0 || rate_hz > MAX_RATE)
            st = ST_RATE;
        else if (data_size > DEF_MAX_FILE_BYTES)
            st = ST_TOO_BIG;
        else
            st = ST_OK;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.channels = chan_count[CHAN_W-1:0];
            r.sample_rate = rate_hz[RATE_W-1:0];
            r.bits_per_sample = width_bits[BITS_W-1:0];
            r.pcm_offset = data_pos;
            r.pcm_bytes = data_size[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic lst);
        walk_byte(pos_model, b);
        if (pos_model != POS_MAX)
            pos_model = pos_model + 1'b1;
        if (lst)
        begin
            results_due = {results_due, summarize()};
            clear_walk();
        end
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, and now and then
    // a calm stretch with no gaps at all.
    function automatic int unsigned pick_gap(input int side);
        int unsigned r;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left[side] = $urandom_range(20, 120);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    initial
    begin
        len_model = '0;
        clear_walk();
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!drv_valid || byte_fired)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end
                else if (byte_queue.size() > 0)
                begin
                    next_byte = byte_queue.pop_front();
                    drv_valid <= 1'b1;
                    drv_byte <= next_byte.data;
                    drv_last <= next_byte.last;
                    send_gap = pick_gap(0);
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                stall_left = pick_gap(1);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
        byte_fired = rst_n && byte_if.valid && byte_if.ready;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            seen.status = status_t'(res_if.status);
            seen.channels = res_if.channels;
            seen.sample_rate = res_if.sample_rate;
            seen.bits_per_sample = res_if.bits_per_sample;
            seen.pcm_offset = res_if.pcm_offset;
            seen.pcm_bytes = res_if.pcm_bytes;
            if (results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transfer: status %0d", seen.status);
            end
            else
            begin
                want = results_due.pop_front();
                if (seen !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: expected st %0d ch %0d rate %0d bits %0d off %0d len %0d",
                                 want.status, want.channels, want.sample_rate,
                                 want.bits_per_sample, want.pcm_offset, want.pcm_bytes);
                        $display("          got st %0d ch %0d rate %0d bits %0d off %0d len %0d",
                                 seen.status, seen.channels, seen.sample_rate,
                                 seen.bits_per_sample, seen.pcm_offset, seen.pcm_bytes);
                    end
                end
            end
        end
        if (byte_fired)
            absorb_byte(byte_if.data_byte, byte_if.last_byte);
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_queue.size() != 0 || drv_valid || results_due.size() != 0);
    endtask

    // The file length register is only touched once the parser has drained.
    task automatic load_length(input logic [POS_W-1:0] v);
        wait_idle();
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        len_model = v;
        @(posedge clk);
    endtask

    task automatic queue_file(input int unsigned n);
        stream_byte_t item;
        for (int unsigned i = 0; i < n; i++)
        begin
            item.data = wav_buf[i];
            item.last = (i == n - 1);
            byte_queue = {byte_queue, item};
        end
        bytes_sent += n;
        files_sent++;
    endtask

    task automatic append_byte(input logic [7:0] b);
        wav_buf = {wav_buf, b};
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            append_byte(v[i * 8 +: 8]);
    endtask

    task automatic start_wav();
        wav_buf.delete();
        put_le(RIFF_TAG, 4);
        put_le(32'd0, 4);
        put_le(WAVE_TAG, 4);
    endtask

    task automatic finish_wav();
        logic [31:0] riff_size;
        riff_size = wav_buf.size() - 8;
        for (int i = 0; i < 4; i++)
            wav_buf[4 + i] = riff_size[i * 8 +: 8];
    endtask

    task automatic add_fmt(input logic [15:0] ftag, input logic [15:0] chn,
                           input logic [31:0] srate, input logic [15:0] sbits,
                           input logic [31:0] flen);
        logic [127:0] img;
        img = {sbits, 16'($urandom), 32'($urandom), srate, chn, ftag};
        put_le(FMT_TAG, 4);
        put_le(flen, 4);
        for (int unsigned i = 0; i < flen + flen[0]; i++)
        begin
            if (i < 16)
                append_byte(img[i * 8 +: 8]);
            else
                append_byte(8'($urandom));
        end
    endtask

    task automatic add_data(input logic [31:0] dlen, input int unsigned dpay);
        put_le(DATA_TAG, 4);
        put_le(dlen, 4);
        repeat (dpay) append_byte(8'($urandom));
        if (dpay == dlen && dlen[0])
            append_byte(8'($urandom));
    endtask

    task automatic add_other(input int unsigned sz);
        put_le($urandom, 4);
        put_le(sz, 4);
        repeat (sz + sz % 2) append_byte(8'($urandom));
    endtask

    task automatic make_plain(input logic [15:0] ftag, input logic [15:0] chn,
                              input logic [31:0] srate, input logic [15:0] sbits,
                              input logic [31:0] flen, input logic [31:0] dlen,
                              input int unsigned dpay);
        start_wav();
        add_fmt(ftag, chn, srate, sbits, flen);
        add_data(dlen, dpay);
        finish_wav();
    endtask

    task automatic add_random_fmt();
        logic [15:0] ftag;
        logic [15:0] chn;
        logic [31:0] srate;
        logic [15:0] sbits;
        logic [31:0] flen;
        int unsigned r;
        ftag = ($urandom_range(0, 99) < 88) ? PCM_FORMAT : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 88)
            chn = $urandom_range(1, 2);
        else if (r < 93)
            chn = 16'd0;
        else if (r < 97)
            chn = 16'd3;
        else
            chn = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 88)
            sbits = $urandom_range(0, 1) ? 16'd8 : 16'd16;
        else if (r < 95)
            sbits = $urandom_range(0, 32);
        else
            sbits = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 45)
            srate = COMMON_RATES[$urandom_range(0, 5)];
        else if (r < 88)
            srate = $urandom_range(1, 96000);
        else if (r < 92)
            srate = 32'd0;
        else if (r < 96)
            srate = 32'd96001;
        else
            srate = $urandom;
        r = $urandom_range(0, 99);
        if (r < 70)
            flen = 32'd16;
        else if (r < 85)
            flen = 32'd18;
        else if (r < 95)
            flen = $urandom_range(17, 24);
        else
            flen = $urandom_range(0, 15);
        add_fmt(ftag, chn, srate, sbits, flen);
    endtask

    task automatic add_random_data();
        int unsigned dlen;
        dlen = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 40);
        add_data(dlen, dlen);
    endtask

    task automatic maybe_other();
        if ($urandom_range(0, 3) == 0)
            add_other($urandom_range(0, 9));
    endtask

    // A well-formed file most of the time; sometimes chunks are out of order,
    // repeated or missing, or a tag byte is damaged.
    task automatic make_random();
        int unsigned r;
        int unsigned idx;
        start_wav();
        maybe_other();
        r = $urandom_range(0, 99);
        if (r < 78)
        begin
            add_random_fmt();
            maybe_other();
            add_random_data();
        end
        else if (r < 88)
        begin
            add_random_data();
            maybe_other();
            add_random_fmt();
        end
        else if (r < 93)
        begin
            add_random_fmt();
            add_random_fmt();
            add_random_data();
        end
        else if (r < 96)
        begin
            add_random_fmt();
            add_random_data();
            add_random_data();
        end
        else if (r < 98)
        begin
            add_random_data();
        end
        else
        begin
            add_random_fmt();
        end
        maybe_other();
        finish_wav();
        if ($urandom_range(0, 99) < 4)
        begin
            idx = $urandom_range(0, 7);
            if (idx >= 4)
                idx = idx + 4;
            wav_buf[idx] = wav_buf[idx] ^ 8'($urandom_range(1, 255));
        end
    endtask

    initial
    begin
        int unsigned r;
        int unsigned copies;
        int unsigned size;
        int unsigned lenv;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed cases: lengths at and around the minimum, the maximum
        // register value, a damaged tag, an early last byte and huge payloads.
        load_length('0);
        start_wav();
        queue_file(1);

        load_length(26'd43);
        make_plain(PCM_FORMAT, 16'd2, 32'd44100, 16'd16, 32'd16, 32'd2, 2);
        queue_file(wav_buf.size());

        load_length(26'd44);
        make_plain(PCM_FORMAT, 16'd1, 32'd8000, 16'd8, 32'd16, 32'd0, 0);
        queue_file(wav_buf.size());

        load_length(26'd46);
        make_plain(PCM_FORMAT, 16'd2, 32'd96000, 16'd16, 32'd16, 32'd1, 1);
        queue_file(wav_buf.size());
        wav_buf[3] = 8'h58;
        queue_file(wav_buf.size());
        queue_file(6);
        wav_buf[3] = 8'h46;
        repeat (6) append_byte(8'($urandom));
        queue_file(wav_buf.size());

        // With the largest length the payload can be announced but never sent.
        load_length(POS_MAX);
        make_plain(PCM_FORMAT, 16'd1, 32'd1, 16'd8, 32'd16, DEF_MAX_FILE_BYTES + 1, 0);
        queue_file(wav_buf.size());
        make_plain(PCM_FORMAT, 16'd1, 32'd1, 16'd8, 32'd16, DEF_MAX_FILE_BYTES, 0);
        queue_file(wav_buf.size());
        make_plain(PCM_FORMAT, 16'd2, 32'd48000, 16'd16, 32'd16, 32'hFFFF_FFFF, 0);
        queue_file(wav_buf.size());
        make_plain(PCM_FORMAT, 16'd2, 32'd22050, 16'd16, 32'd15, 32'd4, 4);
        queue_file(wav_buf.size());

        while (bytes_sent < ITEM_TARGET || files_sent < FILE_TARGET)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                wav_buf.delete();
                repeat ($urandom_range(1, 60)) append_byte(8'($urandom));
            end
            else
            begin
                make_random();
            end
            size = wav_buf.size();
            r = $urandom_range(0, 99);
            if (r < 70)
                lenv = size;
            else if (r < 80)
                lenv = size + $urandom_range(1, 20);
            else if (r < 90)
                lenv = (size > 12) ? size - $urandom_range(1, 12) : 0;
            else if (r < 95)
                lenv = $urandom_range(0, 60);
            else
                lenv = POS_MAX;
            load_length(lenv[POS_W-1:0]);
            copies = $urandom_range(1, 3);
            for (int unsigned c = 0; c < copies; c++)
            begin
                if (c > 0 && $urandom_range(0, 1))
                    repeat ($urandom_range(1, 2))
                        wav_buf[$urandom_range(0, wav_buf.size() - 1)] = 8'($urandom);
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    queue_file($urandom_range(1, size));
                end
                else if (r == 1)
                begin
                    repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
                    queue_file(wav_buf.size());
                end
                else
                begin
                    queue_file(wav_buf.size());
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
hw/rtl/wavhdr_pkg.sv
hw/rtl/wavhdr_if.sv
hw/rtl/wavhdr_walker.sv
hw/rtl/wav_header_parser.sv
test/wav_header_parser_test.sv
